/* src/sha_pkg.sv */
// Package: SHA-256 constants, types and round functions.
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Classified item passed from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_COMP, ST_FOLD, ST_OUT
  } state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] csig0(input logic [31:0] x);
    csig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] csig1(input logic [31:0] x);
    csig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

/* src/sha_front.sv */
// Front part: accepts input beats, drops empty beats, queues commands.
module sha_front #(
  parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_data_byte,
  input  logic          in_byte_present,
  input  logic          in_end_of_message,
  input  logic          in_valid,
  output logic          in_ready,
  output sha_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_pkg::cmd_t     q_r [DEPTH];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_ready  = (cnt_r != AW'(0) + (AW+1)'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign push = in_valid && in_ready && (in_byte_present || in_end_of_message);
  assign pop  = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? ((wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop  ? ((rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= '{data: in_data_byte, has_byte: in_byte_present,
                     eom: in_end_of_message};
    end
  end
endmodule

/* src/sha_back.sv */
// Back part: block packing, padding, 64-round compression, digest output.
module sha_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sha_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  output logic [31:0]   out_digest_word,
  output logic [2:0]    out_word_index,
  output logic          out_last_word,
  output logic          out_valid,
  input  logic          out_ready
);
  sha_pkg::state_t state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, len_r;
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        eom_r, ovalid_r;
  logic        pend_eom_r, pend_eom_nxt;
  logic        wr_byte, start_comp, reload_h;
  logic [7:0]  byte_in;
  logic [31:0] wt, wnew, t1, t2;
  logic [31:0] e, a;

  assign cmd_ready       = (state_r == sha_pkg::ST_IDLE);
  assign out_valid       = ovalid_r;
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  always_comb begin
    wnew = w_r[rnd_r[3:0]] + sha_pkg::sig0(w_r[4'(rnd_r[3:0] + 4'd1)])
         + w_r[4'(rnd_r[3:0] + 4'd9)] + sha_pkg::sig1(w_r[4'(rnd_r[3:0] + 4'd14)]);
    wt = (rnd_r < 6'd16) ? w_r[rnd_r[3:0]] : wnew;
    e  = v_r[4];
    a  = v_r[0];
    t1 = v_r[7] + sha_pkg::csig1(e) + ((e & v_r[5]) ^ (~e & v_r[6]))
       + sha_pkg::ROUND_K[rnd_r] + wt;
    t2 = sha_pkg::csig0(a) + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    state_nxt    = state_r;
    wr_byte      = 1'b0;
    byte_in      = cmd.data;
    start_comp   = 1'b0;
    reload_h     = 1'b0;
    pend_eom_nxt = pend_eom_r;
    case (state_r)
      sha_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.has_byte) begin
            wr_byte = 1'b1;
            if (fill_r == 6'd63) begin
              start_comp   = 1'b1;
              pend_eom_nxt = cmd.eom;
              state_nxt    = sha_pkg::ST_COMP;
            end else if (cmd.eom) begin
              state_nxt = sha_pkg::ST_PAD;
            end
          end else begin
            state_nxt = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        // 0x80 marker is written in the first pad cycle, zeros afterward
        wr_byte = 1'b1;
        byte_in = eom_r ? 8'h80 : 8'h00;
        if (fill_r == 6'd55) begin
          state_nxt = sha_pkg::ST_LEN;
        end else if (fill_r == 6'd63) begin
          start_comp   = 1'b1;
          pend_eom_nxt = 1'b1;
          state_nxt    = sha_pkg::ST_COMP;
        end
      end
      sha_pkg::ST_LEN: begin
        wr_byte = 1'b1;
        byte_in = len_r[63:56];
        if (fill_r == 6'd63) begin
          start_comp   = 1'b1;
          pend_eom_nxt = 1'b0;
          state_nxt    = sha_pkg::ST_COMP;
        end
      end
      sha_pkg::ST_COMP: begin
        if (rnd_r == 6'd63) state_nxt = sha_pkg::ST_FOLD;
      end
      sha_pkg::ST_FOLD: begin
        if (pend_eom_r) state_nxt = sha_pkg::ST_PAD;
        else if (len_r[2:0] == 3'b111) state_nxt = sha_pkg::ST_OUT;
        else state_nxt = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_OUT: begin
        if (ovalid_r && out_ready && idx_r == 3'd7) begin
          reload_h  = 1'b1;
          state_nxt = sha_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
    fill_nxt = wr_byte ? fill_r + 6'd1 : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha_pkg::ST_IDLE;
      fill_r     <= '0;
      bits_r     <= '0;
      len_r      <= '0;
      eom_r      <= 1'b0;
      pend_eom_r <= 1'b0;
      ovalid_r   <= 1'b0;
      idx_r      <= '0;
      rnd_r      <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::H_INIT[i];
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      pend_eom_r <= pend_eom_nxt;
      if (wr_byte) begin
        w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0], byte_in};
      end
      if (state_r == sha_pkg::ST_IDLE && cmd_valid) begin
        if (cmd.has_byte) begin
          bits_r <= bits_r + 64'd8;
          eom_r  <= cmd.eom;
          if (cmd.eom) len_r <= bits_r + 64'd8;
        end else begin
          eom_r <= 1'b1;
          len_r <= bits_r;
        end
      end
      if (state_r == sha_pkg::ST_PAD) eom_r <= 1'b0;
      if (state_r == sha_pkg::ST_LEN) len_r <= {len_r[55:0], 8'hff};
      if (start_comp) begin
        rnd_r <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      if (state_r == sha_pkg::ST_COMP) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r >= 6'd16) w_r[rnd_r[3:0]] <= wnew;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= e;
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= a;
        v_r[0] <= t1 + t2;
      end
      if (state_r == sha_pkg::ST_FOLD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        if (!pend_eom_r && len_r[2:0] == 3'b111) begin
          ovalid_r <= 1'b1;
          idx_r    <= '0;
        end
      end
      if (state_r == sha_pkg::ST_OUT && ovalid_r && out_ready) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd7) ovalid_r <= 1'b0;
      end
      if (reload_h) begin
        for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::H_INIT[i];
        bits_r <= '0;
        len_r  <= '0;
      end
    end
  end
endmodule

/* src/sha256_stream_hasher_core.sv */
// SHA-256 stream hasher: byte beats in, eight digest-word beats out.
// Throughput: one byte beat per cycle while the back is idle; the 64th byte of a block
// stalls the back while it runs the compression rounds and then the fold.
// The front queue takes up to QUEUE_DEPTH non-empty beats during a stall, then in_ready drops.
// End of message: pad and length at one byte per cycle, one or two compressions,
// then eight output beats. Reset (rst_n low) loads the initial hash, clears all counts.
module sha256_stream_hasher_core #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_valid,
  input  logic        out_ready
);
  sha_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_data_byte, .in_byte_present, .in_end_of_message,
    .in_valid, .in_ready, .cmd, .cmd_valid, .cmd_ready
  );

  sha_back u_back (
    .clk, .rst_n, .cmd, .cmd_valid, .cmd_ready, .out_digest_word,
    .out_word_index, .out_last_word, .out_valid, .out_ready
  );
endmodule
